// File: design/srt_pkg.sv
// Shared types and constants of the sorted record table.
// Used by srt_ram, srt_engine and sorted_record_table_unit; depends on nothing.
package srt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int KEY_W       = 16;
    localparam int ISSUED_W    = KEY_W + 1;
    localparam int ID_SUM_W    = KEY_W + 2;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_LIST   = 2'd2;

    localparam logic [2:0] ST_INSERTED      = 3'd0;
    localparam logic [2:0] ST_TABLE_FULL    = 3'd1;
    localparam logic [2:0] ST_IDS_EXHAUSTED = 3'd2;
    localparam logic [2:0] ST_TABLE_EMPTY   = 3'd3;
    localparam logic [2:0] ST_LISTED        = 3'd4;
    localparam logic [2:0] ST_CLEARED       = 3'd5;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [15:0] service_id;
        logic [15:0] pet_id;
    } payload_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        payload_t         payload;
    } entry_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [KEY_W-1:0] record_id;
        payload_t         payload;
        logic             last;
    } res_t;

endpackage

// File: design/srt_ram.sv
// Slot store of the record table: one write port, one read port, registered read.
// Depends on srt_pkg for the entry type and the table depth.
module srt_ram
(
    input  logic                      clk,
    input  logic                      we,
    input  logic [srt_pkg::IDX_W-1:0] waddr,
    input  srt_pkg::entry_t           wdata,
    input  logic [srt_pkg::IDX_W-1:0] raddr,
    output srt_pkg::entry_t           rdata
);

    srt_pkg::entry_t mem [srt_pkg::TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/srt_engine.sv
// Sequencer of the record table: free-slot scan, exchange sort through one
// key comparator, and the list walk. Depends on srt_pkg and srt_ram.
module srt_engine
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [1:0]                mode,
    input  srt_pkg::payload_t         in_payload,
    input  logic [srt_pkg::KEY_W-1:0] first_id,
    output logic                      idle,
    output logic                      res_valid,
    input  logic                      res_ready,
    output srt_pkg::res_t             res
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_LOADI = 4'd2;
    localparam logic [3:0] S_WAITI = 4'd3;
    localparam logic [3:0] S_CMP   = 4'd4;
    localparam logic [3:0] S_PUTI  = 4'd5;
    localparam logic [3:0] S_LREAD = 4'd6;
    localparam logic [3:0] S_LDATA = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    localparam logic [srt_pkg::IDX_W-1:0] LAST_IDX =
        srt_pkg::IDX_W'(srt_pkg::TABLE_DEPTH - 1);
    localparam logic [srt_pkg::IDX_W-1:0] LAST_ROW =
        srt_pkg::IDX_W'(srt_pkg::TABLE_DEPTH - 2);
    localparam logic [srt_pkg::CNT_W-1:0] CNT_FULL =
        srt_pkg::CNT_W'(srt_pkg::TABLE_DEPTH);

    logic [3:0]                         state_reg, state_next;
    logic [3:0]                         ret_reg, ret_next;
    logic [srt_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic [srt_pkg::IDX_W-1:0]          i_reg, i_next;
    logic [srt_pkg::IDX_W-1:0]          x_reg, x_next;
    logic [srt_pkg::TABLE_DEPTH-1:0]    used_reg, used_next;
    logic                               held_used_reg, held_used_next;
    logic [srt_pkg::ISSUED_W-1:0]       issued_reg, issued_next;
    srt_pkg::entry_t                    held_reg, held_next;
    srt_pkg::payload_t                  pay_reg, pay_next;
    srt_pkg::res_t                      res_reg, res_next;

    logic                               we;
    logic [srt_pkg::IDX_W-1:0]          waddr;
    srt_pkg::entry_t                    wdata;
    logic [srt_pkg::IDX_W-1:0]          raddr;
    srt_pkg::entry_t                    rdata;

    logic [srt_pkg::ID_SUM_W-1:0]       id_sum;
    logic [srt_pkg::IDX_W-1:0]          cnt_idx;
    logic [srt_pkg::TABLE_DEPTH-1:0]    later_used;

    srt_ram u_ram
    (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign id_sum  = srt_pkg::ID_SUM_W'(first_id) + srt_pkg::ID_SUM_W'(issued_reg);
    assign cnt_idx = cnt_reg[srt_pkg::IDX_W-1:0];

    // Used slots that come after the one being listed; none left means last.
    always_comb
    begin
        for (int j = 0; j < srt_pkg::TABLE_DEPTH; j++)
        begin
            later_used[j] = used_reg[j] && (srt_pkg::CNT_W'(j) > cnt_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        x_next         = x_reg;
        used_next      = used_reg;
        held_used_next = held_used_reg;
        issued_next    = issued_reg;
        held_next      = held_reg;
        pay_next       = pay_reg;
        res_next       = res_reg;
        we             = 1'b0;
        waddr          = i_reg;
        wdata          = held_reg;
        raddr          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    pay_next = in_payload;
                    res_next = '0;
                    ret_next = S_IDLE;
                    unique case (mode)
                        srt_pkg::MODE_INSERT:
                        begin
                            cnt_next   = '0;
                            state_next = S_SCAN;
                        end
                        srt_pkg::MODE_CLEAR:
                        begin
                            used_next       = '0;
                            res_next.status = srt_pkg::ST_CLEARED;
                            res_next.last   = 1'b1;
                            state_next      = S_EMIT;
                        end
                        srt_pkg::MODE_LIST:
                        begin
                            i_next     = '0;
                            state_next = S_LOADI;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == CNT_FULL)
                begin
                    res_next.status = srt_pkg::ST_TABLE_FULL;
                    res_next.last   = 1'b1;
                    state_next      = S_EMIT;
                end
                else if (!used_reg[cnt_idx])
                begin
                    res_next.last = 1'b1;
                    state_next    = S_EMIT;
                    if (id_sum[srt_pkg::ID_SUM_W-1:srt_pkg::KEY_W] != '0)
                    begin
                        res_next.status = srt_pkg::ST_IDS_EXHAUSTED;
                    end
                    else
                    begin
                        we                 = 1'b1;
                        waddr              = cnt_idx;
                        wdata.key          = id_sum[srt_pkg::KEY_W-1:0];
                        wdata.payload      = pay_reg;
                        used_next[cnt_idx] = 1'b1;
                        issued_next        = issued_reg + 1'b1;
                        res_next.status    = srt_pkg::ST_INSERTED;
                        res_next.record_id = id_sum[srt_pkg::KEY_W-1:0];
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_LOADI:
            begin
                raddr      = i_reg;
                state_next = S_WAITI;
            end
            S_WAITI:
            begin
                held_next      = rdata;
                held_used_next = used_reg[i_reg];
                x_next         = i_reg + 1'b1;
                raddr          = i_reg + 1'b1;
                state_next     = S_CMP;
            end
            S_CMP:
            begin
                // Slot x is swapped with the record held for row i when the held key is the greater.
                if (held_reg.key > rdata.key)
                begin
                    we               = 1'b1;
                    waddr            = x_reg;
                    wdata            = held_reg;
                    used_next[x_reg] = held_used_reg;
                    held_next        = rdata;
                    held_used_next   = used_reg[x_reg];
                end
                if (x_reg == LAST_IDX)
                begin
                    state_next = S_PUTI;
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                    raddr  = x_reg + 1'b1;
                end
            end
            S_PUTI:
            begin
                we               = 1'b1;
                waddr            = i_reg;
                wdata            = held_reg;
                used_next[i_reg] = held_used_reg;
                if (i_reg == LAST_ROW)
                begin
                    cnt_next = '0;
                    if (used_next == '0)
                    begin
                        res_next.status = srt_pkg::ST_TABLE_EMPTY;
                        res_next.last   = 1'b1;
                        ret_next        = S_IDLE;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_LREAD;
                    end
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_LOADI;
                end
            end
            S_LREAD:
            begin
                if (used_reg[cnt_idx])
                begin
                    raddr      = cnt_idx;
                    state_next = S_LDATA;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_LDATA:
            begin
                res_next.status    = srt_pkg::ST_LISTED;
                res_next.record_id = rdata.key;
                res_next.payload   = rdata.payload;
                res_next.last      = (later_used == '0);
                ret_next           = (later_used == '0) ? S_IDLE : S_LREAD;
                cnt_next           = cnt_reg + 1'b1;
                state_next         = S_EMIT;
            end
            S_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            cnt_reg    <= '0;
            i_reg      <= '0;
            x_reg      <= '0;
            used_reg   <= '0;
            issued_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            cnt_reg    <= cnt_next;
            i_reg      <= i_next;
            x_reg      <= x_next;
            used_reg   <= used_next;
            issued_reg <= issued_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg      <= held_next;
        held_used_reg <= held_used_next;
        pay_reg       <= pay_next;
        res_reg       <= res_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT);
    assign res       = res_reg;

endmodule

// File: design/sorted_record_table_unit.sv
// Top level of the sorted record table: configuration register, input
// acceptance and the output register. Depends on srt_pkg and srt_engine.
//
//   Channel   Direction  Handshake            Payload
//   input     in         in_valid/in_ready    mode, pet_id, service_id, day, month, year
//   result    out        out_valid/out_ready  status, record_id, out_pet_id,
//                                             out_service_id, out_day, out_month,
//                                             out_year, last
//   config    in         cfg_wr_en            cfg_wr_data (first_id)
//
// One item is worked on at a time and in_ready is low until its last result
// item has moved into the output register. A clear empties the table and
// answers with a single result; an insert first scans the slots in order for
// a free one, one slot a cycle. A list runs the exchange sort through a single
// key comparator fed by one memory read port, then walks the slots in order,
// giving one result item per used slot and passing over free ones, or gives
// the empty-table answer. Reset clears the used marks at once; there is no
// clearing pass. A result item that finds the output register full waits in
// the engine. A stalled output holds its item while the engine may already
// take and start the next item.
module sorted_record_table_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [15:0] pet_id,
    input  logic [15:0] service_id,
    input  logic [4:0]  day,
    input  logic [3:0]  month,
    input  logic [11:0] year,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] record_id,
    output logic [15:0] out_pet_id,
    output logic [15:0] out_service_id,
    output logic [4:0]  out_day,
    output logic [3:0]  out_month,
    output logic [11:0] out_year,
    output logic        last
);

    logic [srt_pkg::KEY_W-1:0] first_id_reg, first_id_next;
    logic                      out_valid_reg, out_valid_next;
    srt_pkg::res_t             out_reg, out_next;

    srt_pkg::payload_t         in_payload;
    logic                      engine_idle;
    logic                      res_valid;
    logic                      res_ready;
    srt_pkg::res_t             res;
    logic                      start;

    // The engine is the only place an item can be held while it is worked on.
    assign in_ready = engine_idle;
    assign start    = in_valid && in_ready;

    assign in_payload.pet_id     = pet_id;
    assign in_payload.service_id = service_id;
    assign in_payload.day        = day;
    assign in_payload.month      = month;
    assign in_payload.year       = year;

    srt_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .mode       (mode),
        .in_payload (in_payload),
        .first_id   (first_id_reg),
        .idle       (engine_idle),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // The output register takes a new result item when it is empty or being
    // drained in the same cycle.
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        first_id_next  = cfg_wr_en ? cfg_wr_data : first_id_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_id_reg  <= srt_pkg::KEY_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            first_id_reg  <= first_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_reg.status;
    assign record_id      = out_reg.record_id;
    assign out_pet_id     = out_reg.payload.pet_id;
    assign out_service_id = out_reg.payload.service_id;
    assign out_day        = out_reg.payload.day;
    assign out_month      = out_reg.payload.month;
    assign out_year       = out_reg.payload.year;
    assign last           = out_reg.last;

`ifndef NO_ASSERTIONS
    // An idle engine never offers a result item.
    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(engine_idle && res_valid))
        else $error("engine offers a result while idle");

    // Any item with a real mode keeps the engine busy in the next cycle.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (mode == srt_pkg::MODE_INSERT || mode == srt_pkg::MODE_CLEAR ||
                   mode == srt_pkg::MODE_LIST)) |=> !in_ready)
        else $error("engine accepted another item while busy");

    // Only listed records can be followed by another result of the same item.
    a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != srt_pkg::ST_LISTED) |-> last)
        else $error("single result item without last");
`endif

endmodule
